// ===== rtl/two_point_similarity_solver_assert.svh =====
// Assertion macros for the two-point similarity solver checker.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef TWO_POINT_SIMILARITY_SOLVER_ASSERT_SVH
`define TWO_POINT_SIMILARITY_SOLVER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TPSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TPSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tpss_pkg.sv =====
// Shared types and constants for the two-point similarity solver.
// No dependencies; used by the top level and its checker.
package tpss_pkg;

  localparam int COORD_WIDTH          = 24;
  localparam int MATRIX_FRAC_BITS_DEF = 24;
  localparam int OUT_WIDTH            = 32;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_IMG_ZERO   = 2'd1;
  localparam logic [1:0] ST_WORLD_ZERO = 2'd2;
  localparam logic [1:0] ST_DEGENERATE = 2'd3;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] img_ax;
    logic signed [COORD_WIDTH-1:0] img_ay;
    logic signed [COORD_WIDTH-1:0] img_bx;
    logic signed [COORD_WIDTH-1:0] img_by;
    logic signed [COORD_WIDTH-1:0] world_ax;
    logic signed [COORD_WIDTH-1:0] world_ay;
    logic signed [COORD_WIDTH-1:0] world_bx;
    logic signed [COORD_WIDTH-1:0] world_by;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [OUT_WIDTH-1:0] m_11;
    logic signed [OUT_WIDTH-1:0] m_12;
    logic signed [OUT_WIDTH-1:0] m_21;
    logic signed [OUT_WIDTH-1:0] m_22;
    logic signed [OUT_WIDTH-1:0] offset_x;
    logic signed [OUT_WIDTH-1:0] offset_y;
    logic                        saturated;
  } out_word_t;

endpackage

// ===== rtl/two_point_similarity_solver.sv =====
// Two-point similarity solver: scale/rotation matrix and offset from two point pairs.
// Depends on tpss_pkg (word types, status codes, widths).
//
//   channel  | ports                         | word
//   ---------+-------------------------------+-------------------------------
//   input    | in_valid, in_stall, in_data   | tpss_pkg::in_word_t, 8 coords
//   result   | out_valid, out_stall, out_data| tpss_pkg::out_word_t, status+6
//
// One word enters per cycle and one result leaves per cycle while out_stall does not hold the pipe.
// The pipe holds the restoring divider: 33 quotient bits, one bit per stage,
// plus four stages in front (diffs, products, sums, divider setup) and four behind
// (round/saturate, offset products, offset sums, output register).
// Reset (rst_n low, synchronous) clears every stage valid bit; payload is not reset.
// A held result with out_stall high freezes the whole pipe, and in_stall follows.
module two_point_similarity_solver #(
  parameter int MATRIX_FRAC_BITS = tpss_pkg::MATRIX_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tpss_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tpss_pkg::out_word_t  out_data
);

  localparam int CW  = tpss_pkg::COORD_WIDTH;
  localparam int OW  = tpss_pkg::OUT_WIDTH;
  localparam int F   = MATRIX_FRAC_BITS;
  localparam int DW  = CW + 1;          // coordinate differences, negated y
  localparam int PW  = 2 * DW;          // difference products
  localparam int SW  = PW + 1;          // dot, cross, norm squared
  localparam int TW  = SW + F + 2;      // scaled dividend
  localparam int RW  = SW + 2;          // partial remainder
  localparam int QB  = OW + 1;          // quotient bits kept
  localparam int MPW = OW + DW;         // matrix entry times coordinate
  localparam int SSW = MPW + 1;         // sum of two such products
  localparam int XW  = SSW + 1;         // world minus rounded sum

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB-1:0] tl;
    logic [QB-1:0] quo;
    logic          ovf;
    logic          neg;
  } div_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [CW-1:0] x1;
    logic signed [DW-1:0] y1;
    logic signed [CW-1:0] xx1;
    logic signed [CW-1:0] yy1;
    logic [SW:0]          den;
    logic                 neg21;
  } side_t;

  // One restoring step: bring in dividend bit bi, subtract when it fits.
  function automatic div_t div_step(div_t d, logic [SW:0] den, int bi);
    logic [RW-1:0] rs;
    div_t          o;
    rs = {d.rem[SW:0], d.tl[bi]};
    o  = d;
    if (rs >= RW'(den)) begin
      o.rem     = rs - RW'(den);
      o.quo[bi] = 1'b1;
    end else begin
      o.rem = rs;
    end
    return o;
  endfunction

  // Sign the quotient magnitude and clip to 32 bits; returns {clip, value}.
  function automatic logic [OW:0] sat_quo(logic [QB-1:0] q, logic ovf, logic neg);
    logic [QB-1:0] lim;
    logic          clip;
    logic [OW-1:0] val;
    lim  = neg ? (QB'(1) << (OW - 1)) : ((QB'(1) << (OW - 1)) - QB'(1));
    clip = ovf || (q > lim);
    if (clip) begin
      val = neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    end else begin
      val = neg ? (OW'(0) - q[OW-1:0]) : q[OW-1:0];
    end
    return {clip, val};
  endfunction

  // Clip a wide signed value to 32 bits; returns {clip, value}.
  function automatic logic [OW:0] sat_wide(logic [XW-1:0] v);
    logic fits;
    fits = (v[XW-1:OW-1] == {(XW-OW+1){1'b0}}) || (v[XW-1:OW-1] == {(XW-OW+1){1'b1}});
    if (fits) begin
      return {1'b0, v[OW-1:0]};
    end
    return {1'b1, v[XW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}}};
  endfunction

  // Advance every stage together unless the output word is held.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: differences and status ----------------
  logic                 s1_v_r;
  logic signed [DW-1:0] s1_a1_r, s1_b1_r, s1_a2_r, s1_b2_r;
  logic signed [CW-1:0] s1_x1_r, s1_xx1_r, s1_yy1_r;
  logic signed [DW-1:0] s1_y1_r;
  logic [1:0]           s1_status_r;

  logic [DW-1:0] a1_nxt, b1_nxt, a2_nxt, b2_nxt, y1_nxt;
  logic [1:0]    status_nxt;
  logic          img_zero, world_zero;

  always_comb begin
    a1_nxt = {in_data.img_bx[CW-1], in_data.img_bx} - {in_data.img_ax[CW-1], in_data.img_ax};
    // image y is negated, so b1 = (-by) - (-ay)
    b1_nxt = {in_data.img_ay[CW-1], in_data.img_ay} - {in_data.img_by[CW-1], in_data.img_by};
    a2_nxt = {in_data.world_bx[CW-1], in_data.world_bx}
           - {in_data.world_ax[CW-1], in_data.world_ax};
    b2_nxt = {in_data.world_by[CW-1], in_data.world_by}
           - {in_data.world_ay[CW-1], in_data.world_ay};
    y1_nxt = DW'(0) - {in_data.img_ay[CW-1], in_data.img_ay};
    img_zero   = (in_data.img_ax == '0) && (in_data.img_ay == '0) &&
                 (in_data.img_bx == '0) && (in_data.img_by == '0);
    world_zero = (in_data.world_ax == '0) && (in_data.world_ay == '0) &&
                 (in_data.world_bx == '0) && (in_data.world_by == '0);
    if (img_zero) begin
      status_nxt = tpss_pkg::ST_IMG_ZERO;
    end else if (world_zero) begin
      status_nxt = tpss_pkg::ST_WORLD_ZERO;
    end else if ((a1_nxt == '0) && (b1_nxt == '0)) begin
      status_nxt = tpss_pkg::ST_DEGENERATE;
    end else begin
      status_nxt = tpss_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a1_r     <= a1_nxt;
      s1_b1_r     <= b1_nxt;
      s1_a2_r     <= a2_nxt;
      s1_b2_r     <= b2_nxt;
      s1_x1_r     <= in_data.img_ax;
      s1_y1_r     <= y1_nxt;
      s1_xx1_r    <= in_data.world_ax;
      s1_yy1_r    <= in_data.world_ay;
      s1_status_r <= status_nxt;
    end
  end

  // ---------------- stage 2: six difference products ----------------
  logic                 s2_v_r;
  logic signed [PW-1:0] s2_aa_r, s2_bb_r, s2_ab_r, s2_ba_r, s2_a1sq_r, s2_b1sq_r;
  side_t                s2_sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_aa_r   <= s1_a1_r * s1_a2_r;
      s2_bb_r   <= s1_b1_r * s1_b2_r;
      s2_ab_r   <= s1_a1_r * s1_b2_r;
      s2_ba_r   <= s1_b1_r * s1_a2_r;
      s2_a1sq_r <= s1_a1_r * s1_a1_r;
      s2_b1sq_r <= s1_b1_r * s1_b1_r;
      s2_sd_r   <= '{status: s1_status_r, x1: s1_x1_r, y1: s1_y1_r, xx1: s1_xx1_r,
                     yy1: s1_yy1_r, den: '0, neg21: 1'b0};
    end
  end

  // ---------------- stage 3: dot, cross, norm and magnitudes ----------------
  logic          s3_v_r;
  logic [SW-1:0] s3_mdot_r, s3_mcross_r, s3_n_r;
  logic          s3_ndot_r, s3_ncross_r;
  side_t         s3_sd_r;

  logic [SW-1:0] dot_nxt, cross_nxt, n_nxt;
  side_t         sd3_nxt;

  always_comb begin
    dot_nxt   = {s2_aa_r[PW-1], s2_aa_r} + {s2_bb_r[PW-1], s2_bb_r};
    cross_nxt = {s2_ab_r[PW-1], s2_ab_r} - {s2_ba_r[PW-1], s2_ba_r};
    n_nxt     = {1'b0, s2_a1sq_r} + {1'b0, s2_b1sq_r};
    sd3_nxt   = s2_sd_r;
    // -cross is negative only when cross is strictly positive
    sd3_nxt.neg21 = !cross_nxt[SW-1] && (cross_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_mdot_r   <= dot_nxt[SW-1] ? (SW'(0) - dot_nxt) : dot_nxt;
      s3_mcross_r <= cross_nxt[SW-1] ? (SW'(0) - cross_nxt) : cross_nxt;
      s3_ndot_r   <= dot_nxt[SW-1];
      s3_ncross_r <= cross_nxt[SW-1];
      s3_n_r      <= n_nxt;
      s3_sd_r     <= sd3_nxt;
    end
  end

  // ---------------- stage 4: divider setup ----------------
  // Dividend is mag*2^(F+1) + n over 2n, which rounds half away from zero.
  logic          dv_v_r [0:QB];
  div_t          dvd_r  [0:QB];
  div_t          dvc_r  [0:QB];
  side_t         dvs_r  [0:QB];

  logic [TW-1:0] td_nxt, tc_nxt, thd_nxt, thc_nxt;
  logic [SW:0]   den_nxt;
  div_t          d0_nxt, c0_nxt;
  side_t         sd4_nxt;

  always_comb begin
    den_nxt = {s3_n_r, 1'b0};
    td_nxt  = (TW'(s3_mdot_r) << (F + 1)) + TW'(s3_n_r);
    tc_nxt  = (TW'(s3_mcross_r) << (F + 1)) + TW'(s3_n_r);
    thd_nxt = td_nxt >> QB;
    thc_nxt = tc_nxt >> QB;
    d0_nxt  = '{rem: RW'(thd_nxt[SW:0]), tl: td_nxt[QB-1:0], quo: '0,
                ovf: (thd_nxt >= TW'(den_nxt)), neg: s3_ndot_r};
    c0_nxt  = '{rem: RW'(thc_nxt[SW:0]), tl: tc_nxt[QB-1:0], quo: '0,
                ovf: (thc_nxt >= TW'(den_nxt)), neg: s3_ncross_r};
    sd4_nxt     = s3_sd_r;
    sd4_nxt.den = den_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd_r[0] <= d0_nxt;
      dvc_r[0] <= c0_nxt;
      dvs_r[0] <= sd4_nxt;
    end
  end

  // ---------------- divider: one quotient bit per stage, MSB first ----------------
  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dvd_r[k+1] <= div_step(dvd_r[k], dvs_r[k].den, QB - 1 - k);
        dvc_r[k+1] <= div_step(dvc_r[k], dvs_r[k].den, QB - 1 - k);
        dvs_r[k+1] <= dvs_r[k];
      end
    end
  end

  // ---------------- round-off and saturate the matrix entries ----------------
  logic                 m_v_r;
  logic signed [OW-1:0] m11_r, m12_r, m21_r;
  logic                 m_clip_r;
  side_t                m_sd_r;

  logic [OW:0] q11_nxt, q12_nxt, q21_nxt;

  always_comb begin
    q11_nxt = sat_quo(dvd_r[QB].quo, dvd_r[QB].ovf, dvd_r[QB].neg);
    q12_nxt = sat_quo(dvc_r[QB].quo, dvc_r[QB].ovf, dvc_r[QB].neg);
    q21_nxt = sat_quo(dvc_r[QB].quo, dvc_r[QB].ovf, dvs_r[QB].neg21);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m11_r    <= q11_nxt[OW-1:0];
      m12_r    <= q12_nxt[OW-1:0];
      m21_r    <= q21_nxt[OW-1:0];
      m_clip_r <= q11_nxt[OW] | q12_nxt[OW] | q21_nxt[OW];
      m_sd_r   <= dvs_r[QB];
    end
  end

  // ---------------- offset products ----------------
  logic                  p_v_r;
  logic signed [MPW-1:0] p_m11x_r, p_m21y_r, p_m12x_r, p_m22y_r;
  logic signed [OW-1:0]  p_m11_r, p_m12_r, p_m21_r;
  logic                  p_clip_r;
  side_t                 p_sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_m11x_r <= m11_r * m_sd_r.x1;
      p_m21y_r <= m21_r * m_sd_r.y1;
      p_m12x_r <= m12_r * m_sd_r.x1;
      p_m22y_r <= m11_r * m_sd_r.y1;
      p_m11_r  <= m11_r;
      p_m12_r  <= m12_r;
      p_m21_r  <= m21_r;
      p_clip_r <= m_clip_r;
      p_sd_r   <= m_sd_r;
    end
  end

  // ---------------- offset sums, round and drop fraction ----------------
  logic                  r_v_r;
  logic signed [SSW-1:0] r_shx_r, r_shy_r;
  logic signed [OW-1:0]  r_m11_r, r_m12_r, r_m21_r;
  logic                  r_clip_r;
  side_t                 r_sd_r;

  logic [SSW-1:0] sumx_nxt, sumy_nxt;
  localparam logic [SSW-1:0] RND = SSW'(1) << (F - 1);

  always_comb begin
    sumx_nxt = {p_m11x_r[MPW-1], p_m11x_r} + {p_m21y_r[MPW-1], p_m21y_r} + RND;
    sumy_nxt = {p_m12x_r[MPW-1], p_m12x_r} + {p_m22y_r[MPW-1], p_m22y_r} + RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (adv) begin
      r_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_shx_r  <= $signed(sumx_nxt) >>> F;
      r_shy_r  <= $signed(sumy_nxt) >>> F;
      r_m11_r  <= p_m11_r;
      r_m12_r  <= p_m12_r;
      r_m21_r  <= p_m21_r;
      r_clip_r <= p_clip_r;
      r_sd_r   <= p_sd_r;
    end
  end

  // ---------------- output register ----------------
  logic                out_valid_r;
  tpss_pkg::out_word_t out_data_r;
  tpss_pkg::out_word_t out_data_nxt;
  logic [XW-1:0]       ox_nxt, oy_nxt;
  logic [OW:0]         sx_nxt, sy_nxt;

  always_comb begin
    ox_nxt = {{(XW-CW){r_sd_r.xx1[CW-1]}}, r_sd_r.xx1} - {r_shx_r[SSW-1], r_shx_r};
    oy_nxt = {{(XW-CW){r_sd_r.yy1[CW-1]}}, r_sd_r.yy1} - {r_shy_r[SSW-1], r_shy_r};
    sx_nxt = sat_wide(ox_nxt);
    sy_nxt = sat_wide(oy_nxt);
    out_data_nxt        = '0;
    out_data_nxt.status = r_sd_r.status;
    // any failed status leaves every numeric field at zero
    if (r_sd_r.status == tpss_pkg::ST_OK) begin
      out_data_nxt.m_11      = r_m11_r;
      out_data_nxt.m_12      = r_m12_r;
      out_data_nxt.m_21      = r_m21_r;
      out_data_nxt.m_22      = r_m11_r;
      out_data_nxt.offset_x  = sx_nxt[OW-1:0];
      out_data_nxt.offset_y  = sy_nxt[OW-1:0];
      out_data_nxt.saturated = r_clip_r | sx_nxt[OW] | sy_nxt[OW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/tpss_checker.sv =====
// Port-level checker for the two-point similarity solver, bound to the top level.
// Depends on tpss_pkg and two_point_similarity_solver_assert.svh.
`include "two_point_similarity_solver_assert.svh"

module tpss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input tpss_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input tpss_pkg::out_word_t out_data
);

  logic ok_word;
  assign ok_word = out_valid && (out_data.status == tpss_pkg::ST_OK);

  `TPSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result word changed while stalled")
  `TPSS_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall, "input stalled with empty output")
  `TPSS_ASSERT_NOW(a_fail_zero, out_valid && (out_data.status != tpss_pkg::ST_OK), (out_data.m_11 == '0) && (out_data.m_12 == '0) && (out_data.m_21 == '0) && (out_data.offset_x == '0) && (out_data.offset_y == '0) && !out_data.saturated, "failed status with nonzero fields")
  `TPSS_ASSERT_NOW(a_diag_equal, ok_word, out_data.m_22 == out_data.m_11, "diagonal entries differ")
  `TPSS_ASSERT_NOW(a_skew, ok_word && !out_data.saturated, out_data.m_21 == -out_data.m_12, "off-diagonal entries not negated")

endmodule

bind two_point_similarity_solver tpss_checker u_tpss_checker (.*);
